// ===== hw/rtl/i2c_eeprom_master_top_macros.svh =====
// Assertion macros shared by the I2C EEPROM master checker.
// Plain text macros only; no dependencies.
`ifndef I2C_EEPROM_MASTER_TOP_MACROS_SVH
`define I2C_EEPROM_MASTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// Package for the I2C EEPROM master: types, codes and constants.
// Used by the modules and interfaces of the block other than the checker; no dependencies.
package i2cm_pkg;

	// Field and register widths.
	localparam int ADDR_W         = 17;
	localparam int BCOUNT_W       = 16;
	localparam int CFG_DATA_W     = 24;
	localparam int COUNT_BITS_DEF = 16;

	// Action codes carried by a request beat (code 0 is a plain tick).
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_DATA  = 2'd3;

	// Configuration register indexes.
	localparam logic REG_ACK_TIMEOUT = 1'b0;
	localparam logic REG_WRITE_CYCLE = 1'b1;

	// Configuration reset values.
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd255;
	localparam logic [23:0] WRITE_CYCLE_RST = 24'd70000;

	// Device codes: write, read, and the bit set for the upper 64 KiB.
	localparam logic [7:0] DEV_CODE_W  = 8'hA0;
	localparam logic [7:0] DEV_CODE_R  = 8'hA1;
	localparam logic [7:0] DEV_CODE_HI = 8'h02;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DEVW,
		ST_ADDRH,
		ST_ADDRL,
		ST_WDATA,
		ST_NEED,
		ST_RESTART,
		ST_DEVR,
		ST_RDATA,
		ST_STOP_OK,
		ST_STOP_FAIL,
		ST_WWAIT
	} seq_state_t;

	typedef struct packed {
		logic [7:0]  ack_timeout;
		logic [23:0] write_cycle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [ADDR_W-1:0]   mem_address;
		logic [BCOUNT_W-1:0] byte_count;
		logic [7:0]          write_data;
		logic                sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       write_control;
		logic [7:0] rx_byte;
		logic       read_valid;
		logic       need_data;
		logic       busy_res;
		logic       done_res;
		logic       status;
	} res_t;

	// Device code for the address held, read or write direction.
	function automatic logic [7:0] dev_code(input logic rd, input logic upper);
		logic [7:0] code;
		code = rd ? DEV_CODE_R : DEV_CODE_W;
		if (upper) begin
			code = code | DEV_CODE_HI;
		end
		return code;
	endfunction

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// Handshake channels of the I2C EEPROM master: request and result.
// Depends on i2cm_pkg for field widths.
interface i2cm_req_if import i2cm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [ADDR_W-1:0]   mem_address;
	logic [BCOUNT_W-1:0] byte_count;
	logic [7:0]          write_data;
	logic                sda_in;

	modport source (output valid, action, mem_address, byte_count, write_data, sda_in,
		input ready);
	modport sink (input valid, action, mem_address, byte_count, write_data, sda_in,
		output ready);
endinterface

interface i2cm_rsp_if import i2cm_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_drive;
	logic       write_control;
	logic [7:0] rx_byte;
	logic       read_valid;
	logic       need_data;
	logic       busy_res;
	logic       done_res;
	logic       status;

	modport source (output valid, scl_out, sda_out, sda_drive, write_control, rx_byte,
		read_valid, need_data, busy_res, done_res, status, input ready);
	modport sink (input valid, scl_out, sda_out, sda_drive, write_control, rx_byte,
		read_valid, need_data, busy_res, done_res, status, output ready);
endinterface

// ===== hw/rtl/i2cm_cfg.sv =====
// Configuration registers of the I2C EEPROM master.
// Depends on i2cm_pkg for register indexes, reset values and cfg_t.
module i2cm_cfg import i2cm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [7:0]  ack_timeout_q;
	logic [23:0] write_cycle_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RST;
			write_cycle_q <= WRITE_CYCLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[7:0];
				REG_WRITE_CYCLE: write_cycle_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg.ack_timeout       = ack_timeout_q;
	assign cfg.write_cycle_ticks = write_cycle_q;

endmodule

// ===== hw/rtl/i2cm_seq.sv =====
// Bus sequencer of the I2C EEPROM master: one bus phase per accepted beat.
// Depends on i2cm_pkg for the state type, codes and the request/result structs.
module i2cm_seq import i2cm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	input  req_t item,
	output res_t res
);

	seq_state_t            state_q, n_state;
	logic [7:0]            shift_q, n_shift;
	logic [3:0]            bit_q, n_bit;
	logic [1:0]            phase_q, n_phase;
	logic [COUNT_BITS-1:0] left_q, n_left;
	logic [ADDR_W-1:0]     addr_q, n_addr;
	logic [23:0]           wait_q, n_wait;
	logic                  read_q, n_read;
	logic                  scl_q, n_scl;
	logic                  sda_q, n_sda;
	logic                  wc_q, n_wc;
	logic                  drv_q, n_drv;

	logic       ev_rvalid;
	logic [7:0] ev_rbyte;
	logic       ev_done;
	logic       ev_fail;

	// Next-state logic: one phase of start, byte, acknowledge, stop or wait.
	always_comb begin
		logic                  tx_ack;
		logic                  tx_fail;
		logic                  phase_done;
		logic [23:0]           wait_inc;
		logic [7:0]            rx_shift;
		logic [3:0]            bit_inc;
		logic [COUNT_BITS-1:0] left_dec;

		n_state   = state_q;
		n_shift   = shift_q;
		n_bit     = bit_q;
		n_phase   = phase_q;
		n_left    = left_q;
		n_addr    = addr_q;
		n_wait    = wait_q;
		n_read    = read_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_wc      = wc_q;
		n_drv     = drv_q;
		ev_rvalid = 1'b0;
		ev_rbyte  = 8'd0;
		ev_done   = 1'b0;
		ev_fail   = 1'b0;
		tx_ack    = 1'b0;
		tx_fail   = 1'b0;
		phase_done = 1'b0;
		wait_inc  = wait_q + 24'd1;
		rx_shift  = {shift_q[6:0], item.sda_in};
		bit_inc   = bit_q + 4'd1;
		left_dec  = (left_q != '0) ? left_q - COUNT_BITS'(1) : left_q;

		case (state_q)
			ST_IDLE: begin
				if (item.action == ACT_WRITE || item.action == ACT_READ) begin
					n_addr  = item.mem_address;
					n_left  = item.byte_count[COUNT_BITS-1:0];
					n_read  = (item.action == ACT_READ);
					if (item.action == ACT_WRITE) begin
						n_wc = 1'b0;
					end
					n_state = ST_START;
					n_bit   = 4'd0;
					n_phase = 2'd0;
				end
			end

			ST_START, ST_RESTART: begin
				case (phase_q)
					2'd0: begin
						{n_scl, n_sda, n_drv} = 3'b011;
						n_phase = 2'd1;
					end
					2'd1: begin
						{n_scl, n_sda, n_drv} = 3'b111;
						n_phase = 2'd2;
					end
					2'd2: begin
						{n_scl, n_sda, n_drv} = 3'b101;
						n_phase = 2'd3;
					end
					default: begin
						{n_scl, n_sda, n_drv} = 3'b001;
						n_bit   = 4'd0;
						n_phase = 2'd0;
						if (state_q == ST_START) begin
							n_shift = dev_code(1'b0, addr_q[ADDR_W-1]);
							n_state = ST_DEVW;
						end else begin
							n_shift = dev_code(1'b1, addr_q[ADDR_W-1]);
							n_state = ST_DEVR;
						end
					end
				endcase
			end

			ST_DEVW, ST_ADDRH, ST_ADDRL, ST_WDATA, ST_DEVR: begin
				// Eight data bits, then release SDA and poll for acknowledge.
				if (!bit_q[3]) begin
					case (phase_q)
						2'd0: begin
							{n_scl, n_sda, n_drv} = {1'b0, shift_q[7], 1'b1};
							n_phase = 2'd1;
						end
						2'd1: begin
							n_scl   = 1'b1;
							n_phase = 2'd2;
						end
						default: begin
							n_scl   = 1'b0;
							n_shift = {shift_q[6:0], 1'b0};
							n_bit   = bit_inc;
							n_phase = 2'd0;
						end
					endcase
				end else begin
					case (phase_q)
						2'd0: begin
							{n_scl, n_sda, n_drv} = 3'b010;
							n_phase = 2'd1;
						end
						2'd1: begin
							n_scl   = 1'b1;
							n_wait  = 24'd0;
							n_phase = 2'd2;
						end
						default: begin
							if (!item.sda_in) begin
								tx_ack = 1'b1;
							end else begin
								n_wait = wait_inc;
								if (wait_inc >= {16'd0, cfg.ack_timeout}) begin
									tx_fail = 1'b1;
								end
							end
							if (tx_ack || tx_fail) begin
								{n_scl, n_sda, n_drv} = 3'b001;
								n_bit   = 4'd0;
								n_phase = 2'd0;
							end
						end
					endcase
				end

				// Pick the next byte once the slave has acknowledged, or go to the failing STOP on a timeout.
				if (tx_fail) begin
					n_state = ST_STOP_FAIL;
				end else if (tx_ack) begin
					case (state_q)
						ST_DEVW: begin
							n_shift = addr_q[15:8];
							n_state = ST_ADDRH;
						end
						ST_ADDRH: begin
							n_shift = addr_q[7:0];
							n_state = ST_ADDRL;
						end
						ST_ADDRL: begin
							if (read_q) begin
								n_state = ST_RESTART;
							end else begin
								n_state = (left_q == '0) ? ST_STOP_OK : ST_NEED;
							end
						end
						ST_WDATA: begin
							n_left  = left_dec;
							n_state = (left_dec == '0) ? ST_STOP_OK : ST_NEED;
						end
						default: begin
							n_shift = 8'd0;
							n_state = (left_q == '0) ? ST_STOP_OK : ST_RDATA;
						end
					endcase
				end
			end

			ST_NEED: begin
				if (item.action == ACT_DATA) begin
					n_shift = item.write_data;
					n_state = ST_WDATA;
					n_bit   = 4'd0;
					n_phase = 2'd0;
				end
			end

			ST_RDATA: begin
				// Eight sampled bits, then ACK, or NACK on the last byte.
				if (!bit_q[3]) begin
					case (phase_q)
						2'd0: begin
							{n_scl, n_sda, n_drv} = 3'b010;
							n_phase = 2'd1;
						end
						2'd1: begin
							n_scl   = 1'b1;
							n_phase = 2'd2;
						end
						default: begin
							n_shift = rx_shift;
							n_scl   = 1'b0;
							n_bit   = bit_inc;
							n_phase = 2'd0;
							if (bit_inc[3]) begin
								ev_rvalid = 1'b1;
								ev_rbyte  = rx_shift;
								n_left    = left_dec;
							end
						end
					endcase
				end else begin
					case (phase_q)
						2'd0: begin
							{n_scl, n_sda, n_drv} = {1'b0, (left_q == '0), 1'b1};
							n_phase = 2'd1;
						end
						2'd1: begin
							n_scl   = 1'b1;
							n_phase = 2'd2;
						end
						default: begin
							n_scl   = 1'b0;
							n_state = (left_q == '0) ? ST_STOP_OK : ST_RDATA;
							n_bit   = 4'd0;
							n_phase = 2'd0;
						end
					endcase
				end
			end

			ST_STOP_OK, ST_STOP_FAIL: begin
				case (phase_q)
					2'd0: begin
						{n_scl, n_sda, n_drv} = 3'b001;
						n_phase = 2'd1;
					end
					2'd1: begin
						{n_scl, n_sda, n_drv} = 3'b101;
						n_phase = 2'd2;
					end
					default: begin
						{n_scl, n_sda, n_drv} = 3'b111;
						n_phase    = 2'd0;
						phase_done = 1'b1;
					end
				endcase
				if (phase_done) begin
					n_bit = 4'd0;
					if (state_q == ST_STOP_FAIL) begin
						n_wc    = 1'b1;
						n_state = ST_IDLE;
						ev_done = 1'b1;
						ev_fail = 1'b1;
					end else if (read_q) begin
						n_state = ST_IDLE;
						ev_done = 1'b1;
					end else begin
						n_wait  = 24'd0;
						n_state = ST_WWAIT;
					end
				end
			end

			ST_WWAIT: begin
				if (wait_q >= cfg.write_cycle_ticks) begin
					n_wc    = 1'b1;
					n_state = ST_IDLE;
					n_bit   = 4'd0;
					n_phase = 2'd0;
					ev_done = 1'b1;
				end else begin
					n_wait = wait_inc;
				end
			end

			default: begin
				n_state = ST_IDLE;
				n_bit   = 4'd0;
				n_phase = 2'd0;
			end
		endcase
	end

	// Result of this beat: line levels after the update plus events.
	always_comb begin
		res.scl_out       = n_scl;
		res.sda_out       = n_sda;
		res.sda_drive     = n_drv;
		res.write_control = n_wc;
		res.rx_byte       = ev_rbyte;
		res.read_valid    = ev_rvalid;
		res.need_data     = (n_state == ST_NEED);
		res.busy_res      = (n_state != ST_IDLE);
		res.done_res      = ev_done;
		res.status        = ev_fail;
	end

	// Sequencer state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			shift_q <= 8'd0;
			bit_q   <= 4'd0;
			phase_q <= 2'd0;
			left_q  <= '0;
			addr_q  <= '0;
			wait_q  <= 24'd0;
			read_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			wc_q    <= 1'b1;
			drv_q   <= 1'b1;
		end else if (step) begin
			state_q <= n_state;
			shift_q <= n_shift;
			bit_q   <= n_bit;
			phase_q <= n_phase;
			left_q  <= n_left;
			addr_q  <= n_addr;
			wait_q  <= n_wait;
			read_q  <= n_read;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			wc_q    <= n_wc;
			drv_q   <= n_drv;
		end
	end

endmodule

// ===== hw/rtl/i2cm_outreg.sv =====
// Result register of the I2C EEPROM master, driving the result channel.
// Depends on i2cm_pkg for res_t and on i2cm_rsp_if.
module i2cm_outreg import i2cm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  res_t              load_data,
	output logic              load_ready,
	i2cm_rsp_if.source        rsp
);

	logic valid_s1;
	res_t data_s1;

	// The stage takes a new beat when empty or when its beat leaves now.
	assign load_ready = !valid_s1 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_valid && load_ready) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			data_s1 <= load_data;
		end
	end

	assign rsp.valid         = valid_s1;
	assign rsp.scl_out       = data_s1.scl_out;
	assign rsp.sda_out       = data_s1.sda_out;
	assign rsp.sda_drive     = data_s1.sda_drive;
	assign rsp.write_control = data_s1.write_control;
	assign rsp.rx_byte       = data_s1.rx_byte;
	assign rsp.read_valid    = data_s1.read_valid;
	assign rsp.need_data     = data_s1.need_data;
	assign rsp.busy_res      = data_s1.busy_res;
	assign rsp.done_res      = data_s1.done_res;
	assign rsp.status        = data_s1.status;

endmodule

// ===== hw/rtl/i2c_eeprom_master_top.sv =====
// I2C EEPROM master, 17-bit byte address: a request beat is one bus phase (tick), and
// the result beat gives the line levels and events after that phase. Every request
// beat yields exactly one result beat, which passes through the result register;
// one beat is accepted per clock while the result register is empty or being drained,
// so the sustained rate is one beat per clock and rsp.ready alone sets any stall.
// Write the configuration registers only while no transfer is running.
// Depends on i2cm_pkg, i2cm_if, i2cm_cfg, i2cm_seq and i2cm_outreg.
module i2c_eeprom_master_top import i2cm_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	i2cm_req_if.sink              req,
	i2cm_rsp_if.source            rsp
);

	cfg_t cfg;
	req_t item;
	res_t step_res;
	logic load_ready;
	logic step;

	// A request beat is taken whenever the result stage can take its result.
	assign req.ready = load_ready;
	assign step      = req.valid && load_ready;

	assign item.action      = req.action;
	assign item.mem_address = req.mem_address;
	assign item.byte_count  = req.byte_count;
	assign item.write_data  = req.write_data;
	assign item.sda_in      = req.sda_in;

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cm_seq #(
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item),
		.res    (step_res)
	);

	i2cm_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (req.valid),
		.load_data  (step_res),
		.load_ready (load_ready),
		.rsp        (rsp)
	);

endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// Port-level checks for the I2C EEPROM master, bound to the top level.
// Depends on the macros in i2c_eeprom_master_top_macros.svh.
`include "i2c_eeprom_master_top_macros.svh"

module i2cm_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic scl_out,
	input logic sda_drive,
	input logic write_control,
	input logic read_valid,
	input logic need_data,
	input logic busy_res,
	input logic done_res,
	input logic status
);

	// A finished transfer leaves the sequencer idle.
	`I2CM_ASSERT_NOW(a_done_idle, clk, arst_n, rsp_valid && done_res, !busy_res, "done while busy")

	// A failure status only comes with the done beat.
	`I2CM_ASSERT_NOW(a_status_done, clk, arst_n, rsp_valid && status, done_res, "status without done")

	// A received byte lands with SCL low and SDA released, mid-transfer.
	`I2CM_ASSERT_NOW(a_rx_lines, clk, arst_n, rsp_valid && read_valid, !scl_out && !sda_drive && busy_res, "read byte with bad line state")

	// Waiting for write data happens only inside a write with SCL low.
	`I2CM_ASSERT_NOW(a_need_write, clk, arst_n, rsp_valid && need_data, !write_control && !scl_out && busy_res, "need data outside a write")

	// A stalled result beat stays on the channel with its done and status flags unchanged.
	`I2CM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(done_res) && $stable(status), "result beat dropped while stalled")

endmodule

bind i2c_eeprom_master_top i2cm_checker u_i2cm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.scl_out       (rsp.scl_out),
	.sda_drive     (rsp.sda_drive),
	.write_control (rsp.write_control),
	.read_valid    (rsp.read_valid),
	.need_data     (rsp.need_data),
	.busy_res      (rsp.busy_res),
	.done_res      (rsp.done_res),
	.status        (rsp.status)
);

// ===== bench/tb_i2c_eeprom_master_top.sv =====
// Self-checking bench for the I2C EEPROM master: stimulus acts as a simple EEPROM slave,
// and a cycle-true bus sequencer model predicts every result beat.
// Depends on i2cm_pkg, i2cm_if and i2c_eeprom_master_top.
module tb_i2c_eeprom_master_top import i2cm_pkg::*; ();

	// Plain tick: no command, only the bus phase advances.
	localparam logic [1:0] ACT_TICK = 2'd0;
	// A result follows its request through the result register; allow a little slack.
	localparam int SETTLE_CYCLES = 3;
	localparam int HOLD_CYCLES = 200;
	localparam longint RUN_LIMIT = 64'd4_000_000 * 8;

	// Bus sequencer model with the store of expected result beats.
	class eeprom_bus_model;
		logic [7:0]          ack_limit;
		logic [23:0]         prog_ticks;
		seq_state_t          state;
		logic [7:0]          shreg;
		logic [3:0]          bitn;
		logic [1:0]          phase;
		logic [BCOUNT_W-1:0] remaining;
		logic [ADDR_W-1:0]   addr;
		logic [23:0]         waited;
		logic                rd;
		logic                scl, sda, wc, drv;
		res_t                expected_phases[$];
		int                  errors;

		function new();
			ack_limit = ACK_TIMEOUT_RST;
			prog_ticks = WRITE_CYCLE_RST;
			state = ST_IDLE;
			shreg = '0;
			bitn = '0;
			phase = '0;
			remaining = '0;
			addr = '0;
			waited = '0;
			rd = 1'b0;
			scl = 1'b1;
			sda = 1'b1;
			wc = 1'b1;
			drv = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [23:0] val);
			if (idx == REG_ACK_TIMEOUT) begin
				ack_limit = val[7:0];
			end else begin
				prog_ticks = val;
			end
		endfunction

		function void drive(logic s, logic d, logic e);
			scl = s;
			sda = d;
			drv = e;
		endfunction

		function void go(seq_state_t st);
			state = st;
			bitn = '0;
			phase = '0;
		endfunction

		function logic [7:0] dev_byte(logic read);
			return (read ? DEV_CODE_R : DEV_CODE_W) | (addr[16] ? DEV_CODE_HI : 8'h00);
		endfunction

		// START: SCL low with SDA high, SCL high, SDA falls, SCL low.
		function bit start_step();
			case (phase)
				2'd0: begin
					drive(1'b0, 1'b1, 1'b1);
					phase = 2'd1;
				end
				2'd1: begin
					drive(1'b1, 1'b1, 1'b1);
					phase = 2'd2;
				end
				2'd2: begin
					drive(1'b1, 1'b0, 1'b1);
					phase = 2'd3;
				end
				default: begin
					drive(1'b0, 1'b0, 1'b1);
					phase = 2'd0;
					bitn = '0;
					return 1'b1;
				end
			endcase
			return 1'b0;
		endfunction

		// STOP: SDA low, SCL high, then SDA rises.
		function bit stop_step();
			if (phase == 2'd0) begin
				drive(1'b0, 1'b0, 1'b1);
				phase = 2'd1;
			end else if (phase == 2'd1) begin
				drive(1'b1, 1'b0, 1'b1);
				phase = 2'd2;
			end else begin
				drive(1'b1, 1'b1, 1'b1);
				phase = 2'd0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Advance the sequencer by one accepted tick and queue the result it must give.
		function void note_tick(req_t it);
			res_t want;
			int   ack;
			want = '0;
			ack = 0;
			case (state)
				ST_IDLE: begin
					if (it.action == ACT_WRITE || it.action == ACT_READ) begin
						addr = it.mem_address;
						remaining = it.byte_count;
						rd = (it.action == ACT_READ);
						if (!rd) begin
							wc = 1'b0;
						end
						go(ST_START);
					end
				end
				ST_START: begin
					if (start_step()) begin
						shreg = dev_byte(1'b0);
						go(ST_DEVW);
					end
				end
				ST_RESTART: begin
					if (start_step()) begin
						shreg = dev_byte(1'b1);
						go(ST_DEVR);
					end
				end
				ST_DEVW, ST_ADDRH, ST_ADDRL, ST_WDATA, ST_DEVR: begin
					// Eight bits MSB first, then release SDA and poll for the acknowledge.
					if (bitn < 4'd8) begin
						if (phase == 2'd0) begin
							drive(1'b0, shreg[7], 1'b1);
							phase = 2'd1;
						end else if (phase == 2'd1) begin
							scl = 1'b1;
							phase = 2'd2;
						end else begin
							scl = 1'b0;
							shreg = {shreg[6:0], 1'b0};
							bitn = bitn + 4'd1;
							phase = 2'd0;
						end
					end else if (phase == 2'd0) begin
						drive(1'b0, 1'b1, 1'b0);
						phase = 2'd1;
					end else if (phase == 2'd1) begin
						scl = 1'b1;
						waited = '0;
						phase = 2'd2;
					end else if (!it.sda_in) begin
						drive(1'b0, 1'b0, 1'b1);
						ack = 1;
					end else begin
						waited = waited + 24'd1;
						if (waited >= {16'd0, ack_limit}) begin
							drive(1'b0, 1'b0, 1'b1);
							ack = 2;
						end
					end
					if (ack == 2) begin
						go(ST_STOP_FAIL);
					end else if (ack == 1) begin
						case (state)
							ST_DEVW: begin
								shreg = addr[15:8];
								go(ST_ADDRH);
							end
							ST_ADDRH: begin
								shreg = addr[7:0];
								go(ST_ADDRL);
							end
							ST_ADDRL: begin
								if (rd) begin
									go(ST_RESTART);
								end else if (remaining == '0) begin
									go(ST_STOP_OK);
								end else begin
									go(ST_NEED);
								end
							end
							ST_WDATA: begin
								if (remaining != '0) begin
									remaining = remaining - 1'b1;
								end
								if (remaining == '0) begin
									go(ST_STOP_OK);
								end else begin
									go(ST_NEED);
								end
							end
							default: begin
								shreg = '0;
								if (remaining == '0) begin
									go(ST_STOP_OK);
								end else begin
									go(ST_RDATA);
								end
							end
						endcase
					end
				end
				ST_NEED: begin
					if (it.action == ACT_DATA) begin
						shreg = it.write_data;
						go(ST_WDATA);
					end
				end
				ST_RDATA: begin
					// Sample eight bits on SCL high, then ACK, or NACK on the last byte.
					if (bitn < 4'd8) begin
						if (phase == 2'd0) begin
							drive(1'b0, 1'b1, 1'b0);
							phase = 2'd1;
						end else if (phase == 2'd1) begin
							scl = 1'b1;
							phase = 2'd2;
						end else begin
							shreg = {shreg[6:0], it.sda_in};
							scl = 1'b0;
							bitn = bitn + 4'd1;
							phase = 2'd0;
							if (bitn == 4'd8) begin
								want.read_valid = 1'b1;
								want.rx_byte = shreg;
								if (remaining != '0) begin
									remaining = remaining - 1'b1;
								end
							end
						end
					end else if (phase == 2'd0) begin
						drive(1'b0, remaining == '0, 1'b1);
						phase = 2'd1;
					end else if (phase == 2'd1) begin
						scl = 1'b1;
						phase = 2'd2;
					end else begin
						scl = 1'b0;
						if (remaining == '0) begin
							go(ST_STOP_OK);
						end else begin
							go(ST_RDATA);
						end
					end
				end
				ST_STOP_OK: begin
					if (stop_step()) begin
						if (rd) begin
							go(ST_IDLE);
							want.done_res = 1'b1;
						end else begin
							waited = '0;
							go(ST_WWAIT);
						end
					end
				end
				ST_STOP_FAIL: begin
					if (stop_step()) begin
						wc = 1'b1;
						go(ST_IDLE);
						want.done_res = 1'b1;
						want.status = 1'b1;
					end
				end
				ST_WWAIT: begin
					if (waited >= prog_ticks) begin
						wc = 1'b1;
						go(ST_IDLE);
						want.done_res = 1'b1;
					end else begin
						waited = waited + 24'd1;
					end
				end
				default: go(ST_IDLE);
			endcase
			want.scl_out = scl;
			want.sda_out = sda;
			want.sda_drive = drv;
			want.write_control = wc;
			want.need_data = (state == ST_NEED);
			want.busy_res = (state != ST_IDLE);
			expected_phases.push_back(want);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			end
		endfunction

		// Match one result beat against the oldest expectation.
		function void check_phase(res_t got);
			res_t want;
			if (expected_phases.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, expected nothing got %h",
					$time, got);
				return;
			end
			want = expected_phases.pop_front();
			compare("scl_out", want.scl_out, got.scl_out);
			// A released SDA carries no meaningful level.
			if (want.sda_drive) begin
				compare("sda_out", want.sda_out, got.sda_out);
			end
			compare("sda_drive", want.sda_drive, got.sda_drive);
			compare("write_control", want.write_control, got.write_control);
			compare("rx_byte", want.rx_byte, got.rx_byte);
			compare("read_valid", want.read_valid, got.read_valid);
			compare("need_data", want.need_data, got.need_data);
			compare("busy_res", want.busy_res, got.busy_res);
			compare("done_res", want.done_res, got.done_res);
			compare("status", want.status, got.status);
		endfunction
	endclass

	typedef struct {
		logic [1:0]          action;
		logic [ADDR_W-1:0]   addr;
		logic [BCOUNT_W-1:0] count;
		int                  refuse;
	} planned_begin_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	i2cm_req_if req ();
	i2cm_rsp_if rsp ();

	eeprom_bus_model bus;
	planned_begin_t  planned_begins[$];
	logic [7:0]      planned_bytes[$];
	bit              winding_down;
	bit              writes_fail;
	bit              steady;
	bit              hold_request;
	int              refuse_at;
	int              acks_given;
	int              poll_run;

	i2c_eeprom_master_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void plan_transfer(logic [1:0] action, logic [ADDR_W-1:0] addr_v,
		logic [BCOUNT_W-1:0] count, int refuse);
		planned_begin_t pb;
		pb.action = action;
		pb.addr = addr_v;
		pb.count = count;
		pb.refuse = refuse;
		planned_begins.push_back(pb);
	endfunction

	// Choose the next tick from the model's state: mostly well-formed transfers
	// with random content, plus ignored commands and refused acknowledges.
	function automatic req_t next_item();
		req_t           it;
		planned_begin_t pb;
		int             pick;
		it.action = 2'($urandom);
		it.mem_address = ADDR_W'($urandom);
		it.byte_count = BCOUNT_W'($urandom);
		it.write_data = 8'($urandom);
		it.sda_in = 1'($urandom);
		case (bus.state)
			ST_IDLE: begin
				if (planned_begins.size() != 0) begin
					pb = planned_begins.pop_front();
					it.action = pb.action;
					it.mem_address = pb.addr;
					it.byte_count = pb.count;
					refuse_at = pb.refuse;
					acks_given = 0;
					poll_run = 0;
				end else if (!winding_down && $urandom_range(0, 9) < 8) begin
					it.action = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
					case ($urandom_range(0, 7))
						0: it.mem_address = 17'h00000;
						1: it.mem_address = 17'h0FFFF;
						2: it.mem_address = 17'h10000;
						3: it.mem_address = 17'h1FFFF;
						default: ;
					endcase
					pick = $urandom_range(0, 99);
					refuse_at = -1;
					if (pick < 70) begin
						it.byte_count = BCOUNT_W'($urandom_range(0, 4));
					end else if (pick < 95) begin
						it.byte_count = BCOUNT_W'($urandom_range(5, 16));
					end else begin
						// Full-range count; refuse in the header to keep it short.
						refuse_at = $urandom_range(0, 2);
					end
					if (refuse_at < 0 && $urandom_range(0, 7) == 0) begin
						refuse_at = $urandom_range(0, it.byte_count + 3);
					end
					if (writes_fail && it.action == ACT_WRITE) begin
						refuse_at = $urandom_range(0, 2);
					end
					acks_given = 0;
					poll_run = 0;
				end else begin
					it.action = ($urandom_range(0, 1) != 0) ? ACT_TICK : ACT_DATA;
				end
			end
			ST_NEED: begin
				if (planned_bytes.size() != 0) begin
					it.action = ACT_DATA;
					it.write_data = planned_bytes.pop_front();
				end else if ($urandom_range(0, 99) < 85) begin
					it.action = ACT_DATA;
				end
			end
			default: begin
				if ($urandom_range(0, 9) != 0) begin
					it.action = ACT_TICK;
				end
			end
		endcase
		// The slave answers an acknowledge poll at once, after a few high samples, or never.
		if ((bus.state inside {ST_DEVW, ST_ADDRH, ST_ADDRL, ST_WDATA, ST_DEVR}) &&
			bus.bitn == 4'd8 && bus.phase == 2'd2) begin
			if (acks_given == refuse_at) begin
				it.sda_in = 1'b1;
			end else if (poll_run < 3 && poll_run + 1 < int'(bus.ack_limit) &&
				$urandom_range(0, 99) < 25) begin
				it.sda_in = 1'b1;
				poll_run++;
			end else begin
				it.sda_in = 1'b0;
				poll_run = 0;
				acks_given++;
			end
		end
		return it;
	endfunction

	// Offer one beat, with an occasional gap first, and hold it until accepted.
	task automatic offer_tick(req_t it);
		if (!steady && $urandom_range(0, 99) < 19) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= it.action;
		req.mem_address <= it.mem_address;
		req.byte_count <= it.byte_count;
		req.write_data <= it.write_data;
		req.sda_in <= it.sda_in;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		bus.note_tick(it);
	endtask

	task automatic wait_drained();
		while (bus.expected_phases.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One write pulse, then an idle edge so back-to-back writes stay apart.
	task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		bus.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Run transfers until the count is met, let the sequencer return to idle, then drain.
	task automatic run_phase(int transfers, int min_items, bit pressure);
		int    begun;
		int    n;
		req_t  it;
		begun = 0;
		n = 0;
		winding_down = 1'b0;
		while (!winding_down || bus.state != ST_IDLE) begin
			winding_down = (begun >= transfers && n >= min_items);
			if (pressure && n == 50) begin
				hold_request = 1'b1;
			end
			steady = pressure && n >= 100 && n < 350;
			if (pressure && n == 400) begin
				req.valid <= 1'b0;
				wait_drained();
			end
			it = next_item();
			if (bus.state == ST_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ)) begin
				begun++;
			end
			offer_tick(it);
			n++;
		end
		steady = 1'b0;
		req.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus and configuration.
	initial begin
		req.valid <= 1'b0;
		req.action <= ACT_TICK;
		req.mem_address <= '0;
		req.byte_count <= '0;
		req.write_data <= '0;
		req.sda_in <= 1'b1;
		cfg_we <= 1'b0;
		cfg_index <= REG_ACK_TIMEOUT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		winding_down = 1'b0;
		writes_fail = 1'b0;
		steady = 1'b0;
		hold_request = 1'b0;
		refuse_at = -1;
		acks_given = 0;
		poll_run = 0;
		bus = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: upper-bank read, and a write refused until the full timeout.
		plan_transfer(ACT_READ, 17'h1FFFF, 16'd1, -1);
		plan_transfer(ACT_WRITE, 17'h0FFFF, 16'd3, 0);
		run_phase(2, 0, 1'b0);

		// Shortest timeout and write cycle: empty transfers, data extremes, refusals.
		write_reg(REG_ACK_TIMEOUT, 24'd0);
		write_reg(REG_WRITE_CYCLE, 24'd0);
		plan_transfer(ACT_WRITE, 17'h00000, 16'd0, -1);
		plan_transfer(ACT_WRITE, 17'h10000, 16'd2, -1);
		planned_bytes.push_back(8'hFF);
		planned_bytes.push_back(8'h00);
		plan_transfer(ACT_READ, 17'h1FFFF, 16'd0, -1);
		plan_transfer(ACT_READ, 17'h00000, 16'd3, -1);
		plan_transfer(ACT_WRITE, 17'h1ABCD, 16'd2, 3);
		plan_transfer(ACT_READ, 17'h12345, 16'd2, 3);
		plan_transfer(ACT_WRITE, 17'h0A5A5, 16'hFFFF, 1);
		run_phase(7, 0, 1'b0);

		// Random transfers under a long receiver hold-off and a drain pause.
		write_reg(REG_ACK_TIMEOUT, 24'd3);
		write_reg(REG_WRITE_CYCLE, 24'd5);
		run_phase(2, 450, 1'b1);

		// Longest timeout and write cycle: every write is refused before its STOP.
		writes_fail = 1'b1;
		write_reg(REG_ACK_TIMEOUT, 24'd255);
		write_reg(REG_WRITE_CYCLE, 24'hFFFFFF);
		run_phase(1, 0, 1'b0);
		writes_fail = 1'b0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bus.errors == 0) begin
			$display("tb_i2c_eeprom_master_top passed");
		end else begin
			$display("tb_i2c_eeprom_master_top failed");
		end
		$finish;
	end

	// Result side: check each accepted beat; random stalls and one long hold-off.
	initial begin
		int   hold_left;
		res_t got;
		hold_left = 0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got = '{scl_out: rsp.scl_out, sda_out: rsp.sda_out, sda_drive: rsp.sda_drive,
					write_control: rsp.write_control, rx_byte: rsp.rx_byte,
					read_valid: rsp.read_valid, need_data: rsp.need_data,
					busy_res: rsp.busy_res, done_res: rsp.done_res, status: rsp.status};
				bus.check_phase(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= steady || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// Watchdog against a hung handshake.
	initial begin
		#(RUN_LIMIT);
		$display("tb_i2c_eeprom_master_top failed");
		$finish;
	end

endmodule

// ===== i2c_eeprom_master_top.f =====
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_cfg.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2cm_outreg.sv
hw/rtl/i2c_eeprom_master_top.sv
hw/rtl/i2cm_checker.sv
bench/tb_i2c_eeprom_master_top.sv
